FILE: rtl/rlf_pkg.sv
package rlf_pkg;

  localparam int unsigned ChannelsDefault = 16;
  localparam int unsigned AddrChannels    = 16;

  localparam int unsigned LevelW    = 8;
  localparam int unsigned StepW     = 4;
  localparam int unsigned ChanW     = 4;
  localparam int unsigned CountW    = 8;
  localparam int unsigned RandW     = 7;
  localparam int unsigned StepRandW = 3;
  localparam int unsigned DelayW    = 8;
  localparam int unsigned PeakBaseW = 7;
  localparam int unsigned CfgDataW  = 8;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned SinkW     = 8;

  localparam logic [DelayW-1:0]    DelayBaseRst = 8'd127;
  localparam logic [PeakBaseW-1:0] PeakBaseRst  = 7'd100;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDelayBase = 1'b0,
    CfgPeakBase  = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    ReqPwm  = 1'b0,
    ReqFade = 1'b1
  } req_e;

endpackage

FILE: rtl/random_led_fader.sv
// Channel  Direction  Handshake              Payload
// in       sink       in_valid_i/in_ready_o  req_type, timer_count, channel, *_random
// out      source     out_valid_o/out_ready_i sink_low, sink_high, channel_level
// cfg      sink       cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// One word per cycle: a word is accepted whenever the output register is
// empty or being drained; its result appears in the output register on the
// next cycle. Channel state is updated in that same edge (read-modify-write
// in one pass). Reset clears all channel state and loads the base registers.
// A stalled output holds its word and holds off input for as long as it stalls.
module random_led_fader #(
  parameter int unsigned CHANNELS = rlf_pkg::ChannelsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           req_type_i,
  input  logic [rlf_pkg::CountW-1:0]     timer_count_i,
  input  logic [rlf_pkg::ChanW-1:0]      channel_i,
  input  logic [rlf_pkg::RandW-1:0]      delay_random_i,
  input  logic [rlf_pkg::StepRandW-1:0]  step_random_i,
  input  logic [rlf_pkg::RandW-1:0]      peak_random_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [rlf_pkg::SinkW-1:0]      sink_low_o,
  output logic [rlf_pkg::SinkW-1:0]      sink_high_o,
  output logic [rlf_pkg::LevelW-1:0]     channel_level_o,
  input  logic                           cfg_we_i,
  input  logic [rlf_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [rlf_pkg::CfgDataW-1:0]   cfg_wdata_i
);
  import rlf_pkg::*;

  // only the first sixteen channels are addressable or visible
  localparam int unsigned NumCh = (CHANNELS < AddrChannels) ? CHANNELS : AddrChannels;
  localparam int unsigned IdxW  = (NumCh > 1) ? $clog2(NumCh) : 1;

  logic [DelayW-1:0]    delay_base_q;
  logic [PeakBaseW-1:0] peak_base_q;

  logic [LevelW-1:0] level_q [NumCh];
  logic [StepW-1:0]  step_q  [NumCh];
  logic              down_q  [NumCh];
  logic [DelayW-1:0] delay_q [NumCh];
  logic [LevelW-1:0] peak_q  [NumCh];

  logic              out_valid_q;
  logic [SinkW-1:0]  sink_low_q, sink_high_q;
  logic [LevelW-1:0] chan_lvl_q;

  logic              accept;
  logic              is_fade;
  logic              in_range;
  logic [IdxW-1:0]   idx;

  logic [LevelW-1:0] cur_lvl, lvl_d;
  logic [StepW-1:0]  cur_step, step_d;
  logic              cur_down, down_d;
  logic [DelayW-1:0] cur_delay, delay_d;
  logic [LevelW-1:0] cur_peak, peak_d;
  logic [DelayW:0]   delay_sum;

  logic [2*SinkW-1:0] sink_all;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_fade    = (req_e'(req_type_i) == ReqFade);
  assign in_range   = ({1'b0, channel_i} < (ChanW+1)'(NumCh));
  assign idx        = channel_i[IdxW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_base_q <= DelayBaseRst;
      peak_base_q  <= PeakBaseRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgDelayBase: delay_base_q <= cfg_wdata_i;
        CfgPeakBase:  peak_base_q  <= cfg_wdata_i[PeakBaseW-1:0];
        default:      ;
      endcase
    end
  end

  // fade step
  always_comb begin
    cur_lvl   = in_range ? level_q[idx] : '0;
    cur_step  = in_range ? step_q[idx]  : '0;
    cur_down  = in_range ? down_q[idx]  : 1'b0;
    cur_delay = in_range ? delay_q[idx] : '0;
    cur_peak  = in_range ? peak_q[idx]  : '0;
    delay_sum = {1'b0, delay_base_q} + (DelayW+1)'(delay_random_i);

    lvl_d   = cur_lvl;
    step_d  = cur_step;
    down_d  = cur_down;
    delay_d = cur_delay;
    peak_d  = cur_peak;

    if (cur_step != '0) begin
      lvl_d = cur_down ? cur_lvl - LevelW'(cur_step) : cur_lvl + LevelW'(cur_step);
      if (lvl_d > cur_peak) begin
        down_d = !cur_down;
      end else if (lvl_d == '0) begin
        step_d = '0;
        down_d = 1'b0;
      end
    end else if (cur_delay != '0) begin
      delay_d = cur_delay - 1'b1;
    end else begin
      delay_d = delay_sum[DelayW] ? '1 : delay_sum[DelayW-1:0];
      step_d  = StepW'(step_random_i) + 1'b1;
      down_d  = 1'b0;
      peak_d  = LevelW'(peak_base_q) + LevelW'(peak_random_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCh; i++) begin
        level_q[i] <= '0;
        step_q[i]  <= '0;
        down_q[i]  <= 1'b0;
        delay_q[i] <= '0;
        peak_q[i]  <= '0;
      end
    end else if (accept && is_fade && in_range) begin
      level_q[idx] <= lvl_d;
      step_q[idx]  <= step_d;
      down_q[idx]  <= down_d;
      delay_q[idx] <= delay_d;
      peak_q[idx]  <= peak_d;
    end
  end

  // PWM compare; sink_all[15] is channel 0
  for (genvar p = 0; p < 2*SinkW; p++) begin : g_pwm
    if (p < NumCh) begin : g_live
      assign sink_all[2*SinkW-1-p] = (timer_count_i >= level_q[p]);
    end else begin : g_absent
      assign sink_all[2*SinkW-1-p] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sink_low_q  <= is_fade ? '0 : sink_all[2*SinkW-1:SinkW];
      sink_high_q <= is_fade ? '0 : sink_all[SinkW-1:0];
      chan_lvl_q  <= (is_fade && in_range) ? lvl_d : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sink_low_o      = sink_low_q;
  assign sink_high_o     = sink_high_q;
  assign channel_level_o = chan_lvl_q;

  logic step_ok;
  always_comb begin
    step_ok = 1'b1;
    for (int i = 0; i < NumCh; i++) begin
      if (step_q[i] > StepW'(8)) step_ok = 1'b0;
      if (step_q[i] == '0 && down_q[i]) step_ok = 1'b0;
    end
  end

  a_step_sane: assert property (@(posedge clk_i) disable iff (!rst_ni) step_ok)
    else $error("step magnitude or direction out of range");

  a_pwm_no_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !is_fade |=> out_valid_o && channel_level_o == '0)
    else $error("PWM word carries a channel level");

  a_fade_no_sink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_fade |=> out_valid_o && sink_low_o == '0 && sink_high_o == '0)
    else $error("fade word carries sink bits");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(channel_level_o))
    else $error("pending word lost");

endmodule

FILE: tb/sv/tb.sv
module tb;
  import rlf_pkg::*;

  localparam int unsigned StallLimit = 500;
  localparam int unsigned HoldAt     = 500;
  localparam int unsigned HoldLen    = 80;
  localparam int unsigned RandPhases = 7;
  localparam int unsigned PhaseWords = 257;

  typedef struct packed {
    req_e                 req;
    logic [CountW-1:0]    count;
    logic [ChanW-1:0]     chan;
    logic [RandW-1:0]     drand;
    logic [StepRandW-1:0] srand;
    logic [RandW-1:0]     prand;
  } fade_word_t;

  typedef struct packed {
    logic [SinkW-1:0]  sink_low;
    logic [SinkW-1:0]  sink_high;
    logic [LevelW-1:0] level;
  } fade_out_t;

  class fade_scoreboard;
    logic [DelayW-1:0]    delay_base;
    logic [PeakBaseW-1:0] peak_base;
    logic [LevelW-1:0]    level[AddrChannels];
    logic [StepW-1:0]     step_mag[AddrChannels];
    logic                 step_down[AddrChannels];
    logic [DelayW-1:0]    delay_left[AddrChannels];
    logic [LevelW-1:0]    peak[AddrChannels];
    fade_out_t            expected_outputs[$];
    int unsigned          errors;

    function new();
      delay_base = DelayBaseRst;
      peak_base  = PeakBaseRst;
      for (int i = 0; i < AddrChannels; i++) begin
        level[i]      = '0;
        step_mag[i]   = '0;
        step_down[i]  = 1'b0;
        delay_left[i] = '0;
        peak[i]       = '0;
      end
      errors = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
      if (idx == CfgDelayBase) delay_base = val;
      else peak_base = val[PeakBaseW-1:0];
    endfunction

    function void predict_word(fade_word_t w);
      fade_out_t   r;
      int unsigned c;
      int unsigned d;
      r = '0;
      if (w.req == ReqPwm) begin
        for (int i = 0; i < 8; i++) begin
          r.sink_low[7-i]  = (w.count >= level[i]);
          r.sink_high[7-i] = (w.count >= level[8+i]);
        end
      end else begin
        c = int'(w.chan);
        if (step_mag[c] != 0) begin
          if (step_down[c]) level[c] = level[c] - step_mag[c];
          else level[c] = level[c] + step_mag[c];
          if (level[c] > peak[c]) begin
            step_down[c] = !step_down[c];
          end else if (level[c] == 0) begin
            step_mag[c]  = '0;
            step_down[c] = 1'b0;
          end
        end else if (delay_left[c] != 0) begin
          delay_left[c] = delay_left[c] - 1'b1;
        end else begin
          d = delay_base + w.drand;
          delay_left[c] = (d > 255) ? 8'd255 : d[7:0];
          step_mag[c]   = {1'b0, w.srand} + 4'd1;
          step_down[c]  = 1'b0;
          peak[c]       = {1'b0, peak_base} + {1'b0, w.prand};
        end
        r.level = level[c];
      end
      expected_outputs.push_back(r);
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_output(fade_out_t got);
      fade_out_t exp_out;
      if (expected_outputs.size() == 0) begin
        report($sformatf("unexpected word low=%h high=%h level=%h",
                         got.sink_low, got.sink_high, got.level));
      end else begin
        exp_out = expected_outputs.pop_front();
        if (got.sink_low !== exp_out.sink_low)
          report($sformatf("sink_low %h, want %h", got.sink_low, exp_out.sink_low));
        if (got.sink_high !== exp_out.sink_high)
          report($sformatf("sink_high %h, want %h", got.sink_high, exp_out.sink_high));
        if (got.level !== exp_out.level)
          report($sformatf("channel_level %h, want %h", got.level, exp_out.level));
      end
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 req_type_i;
  logic [CountW-1:0]    timer_count_i;
  logic [ChanW-1:0]     channel_i;
  logic [RandW-1:0]     delay_random_i;
  logic [StepRandW-1:0] step_random_i;
  logic [RandW-1:0]     peak_random_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [SinkW-1:0]     sink_low_o;
  logic [SinkW-1:0]     sink_high_o;
  logic [LevelW-1:0]    channel_level_o;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_idx_i;
  logic [CfgDataW-1:0]  cfg_wdata_i;

  fade_scoreboard fade_sb = new();
  bit             send_burst;
  bit             recv_burst;
  int unsigned    idle_cycles;

  random_led_fader dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .timer_count_i  (timer_count_i),
    .channel_i      (channel_i),
    .delay_random_i (delay_random_i),
    .step_random_i  (step_random_i),
    .peak_random_i  (peak_random_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sink_low_o     (sink_low_o),
    .sink_high_o    (sink_high_o),
    .channel_level_o(channel_level_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic fade_word_t mk_word(req_e req, int count, int chan, int drand,
                                         int srand, int prand);
    fade_word_t w;
    w.req   = req;
    w.count = CountW'(count);
    w.chan  = ChanW'(chan);
    w.drand = RandW'(drand);
    w.srand = StepRandW'(srand);
    w.prand = RandW'(prand);
    return w;
  endfunction

  // mostly short delays and low peaks on a few channels so that whole
  // ramp/delay cycles complete
  function automatic fade_word_t rand_word();
    fade_word_t w;
    w.req   = ($urandom_range(0, 9) < 7) ? ReqFade : ReqPwm;
    w.count = CountW'($urandom_range(0, 255));
    w.chan  = ChanW'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 15));
    w.drand = RandW'(($urandom_range(0, 3) != 0) ? $urandom_range(0, 3)
                                                  : $urandom_range(0, 127));
    w.srand = StepRandW'($urandom_range(0, 7));
    w.prand = RandW'($urandom_range(0, 1) ? $urandom_range(0, 15)
                                          : $urandom_range(0, 127));
    return w;
  endfunction

  task automatic send_word(input fade_word_t w);
    int unsigned gap;
    gap = send_burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_type_i     = w.req;
    timer_count_i  = w.count;
    channel_i      = w.chan;
    delay_random_i = w.drand;
    step_random_i  = w.srand;
    peak_random_i  = w.prand;
    in_valid_i     = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    fade_sb.predict_word(w);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (fade_sb.expected_outputs.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    @(posedge clk_i);
    fade_sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  initial begin
    int unsigned delay_cfg[RandPhases];
    int unsigned peak_cfg[RandPhases];
    delay_cfg = '{0, 128, 0, 128, 0, 0, 0};
    peak_cfg  = '{0, 121, 121, 0, 0, 0, 0};
    for (int p = 4; p < RandPhases; p++) begin
      delay_cfg[p] = $urandom_range(0, 128);
      peak_cfg[p]  = $urandom_range(0, 121);
    end

    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    req_type_i     = ReqPwm;
    timer_count_i  = '0;
    channel_i      = '0;
    delay_random_i = '0;
    step_random_i  = '0;
    peak_random_i  = '0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CfgDelayBase;
    cfg_wdata_i    = '0;
    send_burst     = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset values of the base registers
    send_word(mk_word(ReqPwm, 0, 0, 0, 0, 0));
    send_word(mk_word(ReqPwm, 255, 0, 0, 0, 0));
    send_word(mk_word(ReqFade, 0, 0, 127, 7, 127));
    send_word(mk_word(ReqFade, 0, 0, 0, 0, 0));
    send_word(mk_word(ReqFade, 0, 15, 0, 0, 0));
    send_word(mk_word(ReqFade, 0, 15, 0, 0, 0));
    send_word(mk_word(ReqPwm, 0, 0, 0, 0, 0));
    send_word(mk_word(ReqPwm, 1, 0, 0, 0, 0));
    send_word(mk_word(ReqPwm, 8, 0, 0, 0, 0));
    send_word(mk_word(ReqPwm, 7, 0, 0, 0, 0));
    drain();
    write_reg(CfgDelayBase, 8'd0);
    write_reg(CfgPeakBase, 8'd0);
    // peak 0: reverse at once, then clear at zero and reload straight away
    send_word(mk_word(ReqFade, 0, 1, 0, 7, 0));
    send_word(mk_word(ReqFade, 0, 1, 0, 0, 0));
    send_word(mk_word(ReqFade, 0, 1, 0, 0, 0));
    send_word(mk_word(ReqFade, 0, 1, 0, 0, 1));
    send_word(mk_word(ReqFade, 0, 1, 0, 0, 0));
    send_word(mk_word(ReqFade, 0, 1, 0, 0, 0));
    send_word(mk_word(ReqPwm, 1, 0, 0, 0, 0));
    send_word(mk_word(ReqFade, 0, 1, 0, 0, 0));
    send_word(mk_word(ReqFade, 0, 1, 0, 0, 0));
    send_word(mk_word(ReqFade, 0, 1, 5, 3, 9));

    for (int p = 0; p < RandPhases; p++) begin
      drain();
      write_reg(CfgDelayBase, CfgDataW'(delay_cfg[p]));
      write_reg(CfgPeakBase, CfgDataW'(peak_cfg[p]));
      for (int n = 0; n < PhaseWords; n++) begin
        if (n % 64 == 0) send_burst = ($urandom_range(0, 2) == 0);
        send_word(rand_word());
      end
    end

    drain();
    repeat (4) @(negedge clk_i);
    if (fade_sb.errors == 0) begin
      $display("random_led_fader test passed");
    end else begin
      $display("random_led_fader test failed");
    end
    $finish;
  end

  initial begin
    int unsigned gap;
    int unsigned got;
    fade_out_t   seen;
    out_ready_i = 1'b0;
    recv_burst  = 1'b0;
    got         = 0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      gap = recv_burst ? 0 : $urandom_range(0, 5);
      if (got == HoldAt) gap = HoldLen;
      if (gap > 0) begin
        out_ready_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      seen.sink_low  = sink_low_o;
      seen.sink_high = sink_high_o;
      seen.level     = channel_level_o;
      fade_sb.check_output(seen);
      got++;
      if (got % 64 == 0) recv_burst = ($urandom_range(0, 2) == 0);
      @(negedge clk_i);
    end
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("random_led_fader test failed");
        $finish;
      end
    end
  end

endmodule
